// ===== rtl/fpa_pkg.sv =====
// Shared opcodes and widths for the fixed-point ALU.
`default_nettype none
package fpa_pkg;
    localparam int XLEN    = 32;
    localparam int OP_W    = 4;
    localparam int DIV_BPS = 4;

    localparam logic [OP_W-1:0] OP_ADD = 4'd0;
    localparam logic [OP_W-1:0] OP_SUB = 4'd1;
    localparam logic [OP_W-1:0] OP_MUL = 4'd2;
    localparam logic [OP_W-1:0] OP_DIV = 4'd3;
    localparam logic [OP_W-1:0] OP_EQ  = 4'd4;
    localparam logic [OP_W-1:0] OP_NE  = 4'd5;
    localparam logic [OP_W-1:0] OP_LT  = 4'd6;
    localparam logic [OP_W-1:0] OP_GT  = 4'd7;
    localparam logic [OP_W-1:0] OP_LE  = 4'd8;
    localparam logic [OP_W-1:0] OP_GE  = 4'd9;
    localparam logic [OP_W-1:0] OP_MIN = 4'd10;
    localparam logic [OP_W-1:0] OP_MAX = 4'd11;
    localparam logic [OP_W-1:0] OP_INC = 4'd12;
    localparam logic [OP_W-1:0] OP_DEC = 4'd13;
    localparam logic [OP_W-1:0] OP_TOI = 4'd14;
endpackage
`default_nettype wire

// ===== rtl/fixed_point_alu.sv =====
// Top level of the pipelined signed fixed-point ALU.
//
//  channel | ports                                        | direction
//  s       | s_valid s_ready s_req_type s_operand_a/b     | in
//  m       | m_valid m_ready m_result m_flag m_div_by_zero | out
//
// Results pass the input register, the divider stages of 4 restoring steps each
// and the output register. One transfer per cycle when m is not stalled.
// Synchronous active-low reset clears all valid bits.
// A stall at m freezes every stage; s_ready drops while the output is held.
`default_nettype none
module fixed_point_alu import fpa_pkg::*; #(
    parameter int FRAC_BITS = 8
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [OP_W-1:0]        s_req_type,
    input  wire logic signed [XLEN-1:0] s_operand_a,
    input  wire logic signed [XLEN-1:0] s_operand_b,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic signed [XLEN-1:0]      m_result,
    output logic                        m_flag,
    output logic                        m_div_by_zero
);
    localparam int NUM_W  = XLEN + FRAC_BITS;
    localparam int DIV_ST = (NUM_W + DIV_BPS - 1) / DIV_BPS;
    localparam int NUM_P  = DIV_ST * DIV_BPS;

    typedef struct packed {
        logic            valid;
        logic [OP_W-1:0] op;
        logic            neg;
        logic [XLEN-1:0] res;
        logic            flag;
        logic            dz;
        logic [NUM_P-1:0] num;
        logic [XLEN-1:0] rem;
        logic [XLEN-1:0] quo;
        logic [XLEN-1:0] den;
        logic [2*XLEN-1:0] prod;
    } stage_t;

    stage_t pipe_reg  [0:DIV_ST];
    stage_t pipe_next [0:DIV_ST];

    logic            m_valid_reg, m_valid_next;
    logic [XLEN-1:0] m_result_reg, m_result_next;
    logic            m_flag_reg, m_flag_next;
    logic            m_dz_reg, m_dz_next;
    logic            adv;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    always_comb begin
        logic [XLEN-1:0] ua, ub, ma, mb;
        logic lt, gt;
        ua = s_operand_a;
        ub = s_operand_b;
        ma = ua[XLEN-1] ? (~ua + XLEN'(1)) : ua;
        mb = ub[XLEN-1] ? (~ub + XLEN'(1)) : ub;
        lt = s_operand_a < s_operand_b;
        gt = s_operand_b < s_operand_a;
        pipe_next[0]       = '0;
        pipe_next[0].valid = s_valid;
        pipe_next[0].op    = s_req_type;
        pipe_next[0].neg   = ua[XLEN-1] ^ ub[XLEN-1];
        pipe_next[0].num   = {{(NUM_P-XLEN){1'b0}}, ma} << FRAC_BITS;
        pipe_next[0].den   = mb;
        case (s_req_type)
            OP_ADD: pipe_next[0].res = ua + ub;
            OP_SUB: pipe_next[0].res = ua - ub;
            OP_DIV: pipe_next[0].dz = (ub == '0);
            OP_EQ:  pipe_next[0].flag = (ua == ub);
            OP_NE:  pipe_next[0].flag = (ua != ub);
            OP_LT:  pipe_next[0].flag = lt;
            OP_GT:  pipe_next[0].flag = gt;
            OP_LE:  pipe_next[0].flag = !gt;
            OP_GE:  pipe_next[0].flag = !lt;
            OP_MIN: pipe_next[0].res = lt ? ua : ub;
            OP_MAX: pipe_next[0].res = gt ? ua : ub;
            OP_INC: pipe_next[0].res = ua + XLEN'(1);
            OP_DEC: pipe_next[0].res = ua - XLEN'(1);
            OP_TOI: pipe_next[0].res = XLEN'(s_operand_a >>> FRAC_BITS);
            default: pipe_next[0].res = '0;
        endcase
    end

    for (genvar k = 1; k <= DIV_ST; k++) begin : g_st
        logic [XLEN-1:0]  rem_o, quo_o;
        logic [NUM_P-1:0] num_o;

        fpa_div_stage #(.NUM_P(NUM_P)) u_div (
            .rem_in  (pipe_reg[k-1].rem),
            .num_in  (pipe_reg[k-1].num),
            .quo_in  (pipe_reg[k-1].quo),
            .den     (pipe_reg[k-1].den),
            .rem_out (rem_o),
            .num_out (num_o),
            .quo_out (quo_o)
        );

        always_comb begin
            pipe_next[k]     = pipe_reg[k-1];
            pipe_next[k].rem = rem_o;
            pipe_next[k].num = num_o;
            pipe_next[k].quo = quo_o;
            if (k == 1) begin
                pipe_next[k].prod =
                    {{XLEN{1'b0}}, pipe_reg[k-1].num[FRAC_BITS+XLEN-1:FRAC_BITS]}
                    * {{XLEN{1'b0}}, pipe_reg[k-1].den};
            end
            if (k == 2 && pipe_reg[k-1].op == OP_MUL) begin
                pipe_next[k].res = pipe_reg[k-1].prod[FRAC_BITS+XLEN-1:FRAC_BITS]
                                 + {{(XLEN-1){1'b0}}, pipe_reg[k-1].prod[FRAC_BITS-1]};
            end
        end
    end

    always_comb begin
        logic [XLEN-1:0] mag;
        stage_t last;
        last = pipe_reg[DIV_ST];
        mag  = (last.op == OP_DIV) ? last.quo : last.res;
        m_valid_next  = last.valid;
        m_flag_next   = last.flag;
        m_dz_next     = last.dz;
        m_result_next = last.res;
        if (last.op == OP_MUL || last.op == OP_DIV) begin
            m_result_next = last.neg ? (~mag + XLEN'(1)) : mag;
        end
        if (last.dz) begin
            m_result_next = '0;
        end
    end

    for (genvar k = 0; k <= DIV_ST; k++) begin : g_reg
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                pipe_reg[k].valid <= 1'b0;
            end else if (adv) begin
                pipe_reg[k] <= pipe_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg  <= m_valid_next;
            m_result_reg <= m_result_next;
            m_flag_reg   <= m_flag_next;
            m_dz_reg     <= m_dz_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_result      = m_result_reg;
    assign m_flag        = m_flag_reg;
    assign m_div_by_zero = m_dz_reg;

    a_dz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_div_by_zero |-> m_result == '0 && !m_flag)
        else $error("divide by zero result not cleared");

    a_flag_cmp: assert property (@(posedge aclk) disable iff (!aresetn)
        pipe_reg[DIV_ST].valid && pipe_reg[DIV_ST].flag |->
        pipe_reg[DIV_ST].res == '0 && !pipe_reg[DIV_ST].dz)
        else $error("flag raised with nonzero result");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(pipe_reg[0].valid) && $stable(pipe_reg[DIV_ST].valid))
        else $error("pipeline advanced during stall");

    a_dz_div: assert property (@(posedge aclk) disable iff (!aresetn)
        pipe_reg[0].valid && pipe_reg[0].dz |-> pipe_reg[0].op == OP_DIV)
        else $error("zero divisor flag on non-divide");
endmodule
`default_nettype wire

// ===== rtl/fpa_div_stage.sv =====
// Restoring divider slice: DIV_BPS quotient bits per pipeline stage.
`default_nettype none
module fpa_div_stage import fpa_pkg::*; #(
    parameter int NUM_P = 40
) (
    input  wire logic [XLEN-1:0]  rem_in,
    input  wire logic [NUM_P-1:0] num_in,
    input  wire logic [XLEN-1:0]  quo_in,
    input  wire logic [XLEN-1:0]  den,
    output logic      [XLEN-1:0]  rem_out,
    output logic      [NUM_P-1:0] num_out,
    output logic      [XLEN-1:0]  quo_out
);
    always_comb begin
        logic [XLEN:0]    r;
        logic [XLEN-1:0]  rm;
        logic [NUM_P-1:0] n;
        logic [XLEN-1:0]  q;
        rm = rem_in;
        n  = num_in;
        q  = quo_in;
        for (int i = 0; i < DIV_BPS; i++) begin
            r = {rm, n[NUM_P-1]};
            n = {n[NUM_P-2:0], 1'b0};
            if (r >= {1'b0, den}) begin
                r = r - {1'b0, den};
                q = {q[XLEN-2:0], 1'b1};
            end else begin
                q = {q[XLEN-2:0], 1'b0};
            end
            rm = r[XLEN-1:0];
        end
        rem_out = rm;
        num_out = n;
        quo_out = q;
    end
endmodule
`default_nettype wire
